FILE: hdl/ease_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------------------------
// Easing curve evaluator package
// Curve codes, Q28 constants, the fixed point helpers and the per-stage datapath function
// shared by the pipeline.
// ---------------------------------------------------------------------------------------------
package ease_pkg;

   localparam int unsigned EASE_TIME_FRAC_BITS = 16;
   localparam int unsigned EASE_QF             = 28;
   // Stage 0 prepares the operand, the last stage applies the in/out/in-out folding.
   localparam int unsigned EASE_STAGES         = 34;

   localparam logic [4:0]         MODE_UNUSED = 5'd31;
   localparam logic [28:0]        QONE_U      = 29'h1000_0000;
   localparam logic signed [31:0] QONE        = 32'sd268435456;
   localparam logic signed [31:0] HALF_PI_Q   = 32'sd421657428;
   localparam logic signed [31:0] LN2_Q       = 32'sd186065279;
   localparam logic signed [31:0] BACK_S_Q    = 32'sd456764403;
   localparam logic signed [31:0] BACK_S2_Q   = 32'sd696565715;

   // Bounce segment thresholds and offsets on 11 * w, and the segment constants.
   localparam logic signed [33:0] BNC_T1  = 34'sd1073741824;
   localparam logic signed [33:0] BNC_T2  = 34'sd2147483648;
   localparam logic signed [33:0] BNC_T3  = 34'sd2684354560;
   localparam logic signed [33:0] BNC_O2  = 34'sd1610612736;
   localparam logic signed [33:0] BNC_O3  = 34'sd2415919104;
   localparam logic signed [33:0] BNC_O4  = 34'sd2818572288;
   localparam logic [27:0]        BNC_C2  = 28'd201326592;
   localparam logic [27:0]        BNC_C3  = 28'd251658240;
   localparam logic [27:0]        BNC_C4  = 28'd264241152;
   localparam logic signed [33:0] Q34     = 34'sd268435456;

   // Exact reciprocals for floor division of values below 2^31 by small constants.
   localparam logic [31:0] SIN_DIV_M [5] = '{
      32'(((64'd1 << 38) + 64'd109) / 64'd110),
      32'(((64'd1 << 38) + 64'd71) / 64'd72),
      32'(((64'd1 << 37) + 64'd41) / 64'd42),
      32'(((64'd1 << 36) + 64'd19) / 64'd20),
      32'(((64'd1 << 34) + 64'd5) / 64'd6)
   };
   localparam logic [5:0] SIN_DIV_SH [5] = '{6'd38, 6'd38, 6'd37, 6'd36, 6'd34};

   localparam logic [31:0] POW_DIV_M [10] = '{
      32'(((64'd1 << 35) + 64'd9) / 64'd10),
      32'(((64'd1 << 35) + 64'd8) / 64'd9),
      32'(((64'd1 << 34) + 64'd7) / 64'd8),
      32'(((64'd1 << 34) + 64'd6) / 64'd7),
      32'(((64'd1 << 34) + 64'd5) / 64'd6),
      32'(((64'd1 << 34) + 64'd4) / 64'd5),
      32'(((64'd1 << 33) + 64'd3) / 64'd4),
      32'(((64'd1 << 33) + 64'd2) / 64'd3),
      32'(((64'd1 << 32) + 64'd1) / 64'd2),
      32'(64'd1 << 31)
   };
   localparam logic [5:0] POW_DIV_SH [10] = '{6'd35, 6'd35, 6'd34, 6'd34, 6'd34,
                                               6'd34, 6'd33, 6'd33, 6'd32, 6'd31};

   typedef enum logic [3:0] {
      FAM_LINEAR, FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT, FAM_SINE,
      FAM_EXPO, FAM_CIRC, FAM_ELASTIC, FAM_BACK, FAM_BOUNCE
   } fam_type;

   typedef enum logic [1:0] {KIND_IN, KIND_OUT, KIND_INOUT} kind_type;

   typedef struct packed {
      fam_type  fam;
      kind_type kind;
   } mode_dec_type;

   typedef struct packed {
      fam_type            fam;
      kind_type           kind;
      logic               hi;
      logic               vz;
      logic               vone;
      logic [28:0]        v;
      logic signed [31:0] vv;
      logic signed [31:0] p;
      logic signed [31:0] bk;
      logic signed [35:0] bn_d;
      logic [27:0]        bn_c;
      logic signed [31:0] bn;
      logic signed [31:0] el;
      logic               sn_neg;
      logic [28:0]        sn_f;
      logic signed [31:0] sn_z;
      logic signed [31:0] sn_z2;
      logic signed [31:0] sn_acc;
      logic signed [31:0] sn_m;
      logic signed [31:0] sn_val;
      logic [3:0]         pw_k;
      logic [27:0]        pw_f;
      logic signed [31:0] pw_x;
      logic signed [31:0] pw_e;
      logic signed [31:0] pw_m;
      logic signed [31:0] pw_val;
      logic [57:0]        sq_rem;
      logic [28:0]        sq_root;
      logic signed [35:0] c;
      logic signed [35:0] r;
   } ease_stage_type;

   function automatic mode_dec_type decode_mode(input logic [4:0] mode);
      mode_dec_type d;
      logic [3:0]   fc;
      logic [1:0]   kc;
      d.fam  = FAM_LINEAR;
      d.kind = KIND_IN;
      fc     = 4'd1;
      kc     = 2'd0;
      for (int m = 1; m <= 30; m++) begin
         if (mode == 5'(m)) begin
            d.fam  = fam_type'(fc);
            d.kind = kind_type'(kc);
         end
         if (kc == 2'd2) begin
            kc = 2'd0;
            fc = fc + 4'd1;
         end else begin
            kc = kc + 2'd1;
         end
      end
      return d;
   endfunction

   // Q28 product rounded half up.
   function automatic logic signed [35:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] pr;
      pr = a * b;
      pr = pr + 64'sd134217728;
      return 36'(pr >>> EASE_QF);
   endfunction

   function automatic logic signed [31:0] div_recip(input logic signed [31:0] x,
                                                    input logic [31:0] m,
                                                    input logic [5:0] sh);
      logic [62:0] pr;
      pr = 63'(x[30:0]) * 63'(m);
      return 32'(pr >> sh);
   endfunction

   function automatic logic signed [31:0] sx29(input logic [28:0] v);
      return $signed({3'b000, v});
   endfunction

   // One pipeline stage: every unit that has a step at this stage takes it, the rest hold.
   function automatic ease_stage_type ease_stage(input logic [5:0] idx,
                                                 input ease_stage_type s);
      ease_stage_type     n;
      logic signed [31:0] bs;
      logic signed [33:0] vx;
      logic signed [33:0] u;
      logic signed [33:0] ph;
      logic signed [33:0] y;
      logic [58:0]        trial;
      logic [4:0]         b;
      logic [3:0]         pj;
      logic [2:0]         sj;
      logic signed [35:0] h;
      n     = s;
      bs    = (s.kind == KIND_INOUT) ? BACK_S2_Q : BACK_S_Q;
      vx    = $signed({5'b00000, s.v});
      u     = '0;
      ph    = '0;
      y     = '0;
      trial = '0;
      b     = 5'(6'd31 - idx);
      pj    = 4'((idx - 6'd4) >> 1);
      sj    = 3'((idx - 6'd5) >> 1);
      h     = '0;

      if (idx == 6'd1) begin
         n.vv = 32'(mulq(sx29(s.v), sx29(s.v)));
         n.p  = n.vv;
         n.bk = 32'(mulq(bs + QONE, sx29(s.v)));
         u    = $signed({5'b00000, QONE_U - s.v}) * 34'sd11;
         if (u < BNC_T1) begin
            n.bn_d = 36'(u);
            n.bn_c = '0;
         end else if (u < BNC_T2) begin
            n.bn_d = 36'(u - BNC_O2);
            n.bn_c = BNC_C2;
         end else if (u < BNC_T3) begin
            n.bn_d = 36'(u - BNC_O3);
            n.bn_c = BNC_C3;
         end else begin
            n.bn_d = 36'(u - BNC_O4);
            n.bn_c = BNC_C4;
         end
         if (s.fam == FAM_SINE) begin
            ph = vx + Q34;
         end else begin
            ph = vx * 34'sd10 - Q34 * 34'sd11;
         end
         n.sn_neg = ph[29];
         n.sn_f   = ph[28] ? (QONE_U - {1'b0, ph[27:0]}) : {1'b0, ph[27:0]};
         y        = vx * 34'sd10 - Q34 * 34'sd10;
         n.pw_k   = 4'(-(y >>> EASE_QF));
         n.pw_f   = y[27:0];
      end

      if (idx == 6'd2) begin
         if (s.fam >= FAM_CUBIC) begin
            n.p = 32'(mulq(s.p, sx29(s.v)));
         end
         n.bk     = s.bk - bs;
         n.bn_d   = mulq(32'(s.bn_d), 32'(s.bn_d));
         n.sn_z   = 32'(mulq(sx29(s.sn_f), HALF_PI_Q));
         n.pw_x   = 32'(mulq($signed({4'b0000, s.pw_f}), LN2_Q));
         n.pw_e   = QONE;
         n.sn_acc = QONE;
         n.sq_rem = 58'(QONE - s.vv) << EASE_QF;
         n.sq_root = '0;
      end

      if (idx == 6'd3) begin
         if (s.fam >= FAM_QUART) begin
            n.p = 32'(mulq(s.p, sx29(s.v)));
         end
         n.bk    = 32'(mulq(s.vv, s.bk));
         n.bn    = QONE - (32'(s.bn_d >>> 4) + $signed({4'b0000, s.bn_c}));
         n.sn_z2 = 32'(mulq(s.sn_z, s.sn_z));
      end

      if (idx == 6'd4 && s.fam == FAM_QUINT) begin
         n.p = 32'(mulq(s.p, sx29(s.v)));
      end

      // exp(x) by Horner: multiply on odd stages, divide and add one on even stages.
      if (idx >= 6'd3 && idx <= 6'd21 && idx[0]) begin
         n.pw_m = 32'(mulq(s.pw_x, s.pw_e));
      end
      if (idx >= 6'd4 && idx <= 6'd22 && !idx[0]) begin
         n.pw_e = QONE + div_recip(s.pw_m, POW_DIV_M[pj], POW_DIV_SH[pj]);
      end
      if (idx == 6'd23) begin
         n.pw_val = s.pw_e >>> s.pw_k;
      end

      // Sine series in z^2 on the same two-stage rhythm.
      if (idx >= 6'd4 && idx <= 6'd12 && !idx[0]) begin
         n.sn_m = 32'(mulq(s.sn_z2, s.sn_acc));
      end
      if (idx >= 6'd5 && idx <= 6'd13 && idx[0]) begin
         n.sn_acc = QONE - div_recip(s.sn_m, SIN_DIV_M[sj], SIN_DIV_SH[sj]);
      end
      if (idx == 6'd14) begin
         n.sn_val = 32'(mulq(s.sn_z, s.sn_acc));
      end
      if (idx == 6'd15 && s.sn_neg) begin
         n.sn_val = -s.sn_val;
      end

      if (idx == 6'd24) begin
         if (s.vz) begin
            n.el = '0;
         end else if (s.vone) begin
            n.el = QONE;
         end else begin
            n.el = 32'(-mulq(s.pw_val, s.sn_val));
         end
      end

      // Square root, one result bit per stage from the top.
      if (idx >= 6'd3 && idx <= 6'd31) begin
         trial = (59'(s.sq_root) << (b + 5'd1)) + (59'd1 << (6'(b) << 1));
         if (trial <= 59'(s.sq_rem)) begin
            n.sq_rem     = 58'(59'(s.sq_rem) - trial);
            n.sq_root[b] = 1'b1;
         end
      end

      if (idx == 6'd32) begin
         case (s.fam)
            FAM_LINEAR:  n.c = 36'(sx29(s.v));
            FAM_QUAD:    n.c = 36'(s.p);
            FAM_CUBIC:   n.c = 36'(s.p);
            FAM_QUART:   n.c = 36'(s.p);
            FAM_QUINT:   n.c = 36'(s.p);
            FAM_SINE:    n.c = 36'(QONE - s.sn_val);
            FAM_EXPO:    n.c = s.vz ? 36'sd0 : 36'(s.pw_val);
            FAM_CIRC:    n.c = 36'(QONE - sx29(s.sq_root));
            FAM_ELASTIC: n.c = 36'(s.el);
            FAM_BACK:    n.c = 36'(s.bk);
            FAM_BOUNCE:  n.c = 36'(s.bn);
            default:     n.c = '0;
         endcase
      end

      if (idx == 6'd33) begin
         h = (s.c + 36'sd1) >>> 1;
         case (s.kind)
            KIND_IN:    n.r = s.c;
            KIND_OUT:   n.r = 36'(QONE) - s.c;
            KIND_INOUT: n.r = s.hi ? (36'(QONE) - h) : h;
            default:    n.r = s.c;
         endcase
      end
      return n;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/easing_curve_evaluator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------------------------
// Easing curve evaluator
// Pipelined evaluator of 31 animation easing curves on a normalised time value.
// ---------------------------------------------------------------------------------------------
// Usage:
// Time samples arrive as req_ beats (unsigned Q1.F, values above 1.0 are clamped) and each
// yields exactly one rsp_ beat holding the curve value in signed Q2.F, clamped to +/-2.0.
// The curve is chosen by the ease_mode register at byte address 0 of the APB port; a write
// of the unused code 31 is ignored. Change the mode only while no beat is in flight.
// The datapath is a 34-stage pipeline plus an output register. One sample is accepted per
// cycle as long as the pipeline has room; the depth is set by the exponential series
// (ten multiply and divide steps) and the bit-serial square root.
// Each stage holds its own beat, so when the receiver stalls the pipeline compacts its
// bubbles and keeps accepting until every stage is full; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and sets the mode to linear.
// ---------------------------------------------------------------------------------------------
module easing_curve_evaluator_top
   import ease_pkg::*;
#(
   parameter int unsigned TIME_FRAC_BITS = EASE_TIME_FRAC_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [TIME_FRAC_BITS:0]          req_time_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [TIME_FRAC_BITS+2:0]      rsp_eased_value,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [2:0]                       paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int unsigned TIME_W     = TIME_FRAC_BITS + 1;
   localparam int unsigned OUT_W      = TIME_FRAC_BITS + 3;
   localparam int unsigned TIME_SHIFT = EASE_QF - TIME_FRAC_BITS;
   localparam logic [TIME_W-1:0]      TIME_ONE = TIME_W'(1) << TIME_FRAC_BITS;
   localparam logic signed [35:0]     RND_HALF = 36'sd1 <<< (TIME_SHIFT - 1);
   localparam logic signed [35:0]     SAT_POS  = 36'sd1 <<< (TIME_FRAC_BITS + 1);
   localparam logic signed [OUT_W-1:0] SAT_OUT = OUT_W'(SAT_POS);

   logic [4:0]              ease_mode_ff;
   logic [4:0]              ease_mode_in;
   logic                    csr_write;

   ease_stage_type          st_ff [EASE_STAGES];
   ease_stage_type          st_in [EASE_STAGES];
   logic [EASE_STAGES-1:0]  vld_ff;
   logic [EASE_STAGES:0]    move;
   logic                    out_vld_ff;
   logic signed [OUT_W-1:0] out_val_ff;
   logic signed [OUT_W-1:0] out_val_in;

   mode_dec_type            dec;
   logic [TIME_W-1:0]       tsat;
   logic [28:0]             t28;
   logic [29:0]             t2;
   logic signed [35:0]      rnd;
   logic signed [35:0]      rsh;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && !paddr[2];
   assign prdata    = paddr[2] ? 32'd0 : {27'd0, ease_mode_ff};

   always_comb begin
      ease_mode_in = ease_mode_ff;
      if (csr_write && pwdata[4:0] != MODE_UNUSED) begin
         ease_mode_in = pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ease_mode_ff <= '0;
      end else begin
         ease_mode_ff <= ease_mode_in;
      end
   end

   // Stage 0: clamp the time, move it to Q28 and fold it for the out and in-out forms.
   always_comb begin
      dec  = decode_mode(ease_mode_ff);
      tsat = (req_time_value > TIME_ONE) ? TIME_ONE : req_time_value;
      t28  = 29'(tsat) << TIME_SHIFT;
      t2   = {t28, 1'b0};
      st_in[0]      = '0;
      st_in[0].fam  = dec.fam;
      st_in[0].kind = dec.kind;
      st_in[0].hi   = (t28 >= (QONE_U >> 1));
      case (dec.kind)
         KIND_IN:    st_in[0].v = t28;
         KIND_OUT:   st_in[0].v = QONE_U - t28;
         KIND_INOUT: st_in[0].v = st_in[0].hi ? 29'({QONE_U, 1'b0} - t2) : 29'(t2);
         default:    st_in[0].v = t28;
      endcase
      st_in[0].vz   = (st_in[0].v == '0);
      st_in[0].vone = (st_in[0].v == QONE_U);
   end

   for (genvar k = 1; k < EASE_STAGES; k++) begin : g_stage
      assign st_in[k] = ease_stage(6'(k), st_ff[k-1]);
   end

   // A stage takes a new beat when it is empty or its occupant moves on.
   assign move[EASE_STAGES] = !out_vld_ff || rsp_ready;
   for (genvar k = 0; k < EASE_STAGES; k++) begin : g_move
      assign move[k] = !vld_ff[k] || move[k+1];
   end
   assign req_ready = move[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (move[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < EASE_STAGES; k++) begin
            if (move[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (move[EASE_STAGES]) begin
            out_vld_ff <= vld_ff[EASE_STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < EASE_STAGES; k++) begin
         if (move[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (move[EASE_STAGES]) begin
         out_val_ff <= out_val_in;
      end
   end

   // Output: round half up to Q2.F and clamp to +/-2.0.
   always_comb begin
      rnd = st_ff[EASE_STAGES-1].r + RND_HALF;
      rsh = rnd >>> TIME_SHIFT;
      if (rsh > SAT_POS) begin
         out_val_in = OUT_W'(SAT_POS);
      end else if (rsh < -SAT_POS) begin
         out_val_in = OUT_W'(-SAT_POS);
      end else begin
         out_val_in = OUT_W'(rsh);
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_eased_value = out_val_ff;

`ifndef SYNTHESIS
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled although the receiver is ready");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_eased_value <= SAT_OUT && rsp_eased_value >= -SAT_OUT))
      else $error("result outside the saturation range");

   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      csr_write && pwdata[4:0] == MODE_UNUSED |=> $stable(ease_mode_ff))
      else $error("unused curve code was taken");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------------------------
// Easing curve evaluator testbench
// Drives time samples through every curve and compares each result beat against a known value
// or a Q28 fixed point model of the curves, under random idling on both sides of the block.
// ---------------------------------------------------------------------------------------------
module testbench
   import ease_pkg::*;
();

   localparam int          CLK_HALF    = 10;
   localparam int          DRAIN_WAIT  = 40;
   localparam longint      CYCLE_LIMIT = 400000;
   localparam int          SEG_ITEMS   = 30;
   localparam logic [2:0]  ADDR_MODE   = 3'd0;
   localparam logic [2:0]  ADDR_SPARE  = 3'd4;
   localparam logic [4:0]  MODE_LINEAR = 5'd0;
   localparam logic [4:0]  MODE_QUAD_IN = 5'd1;
   localparam logic [4:0]  MODE_EXPO_IN = 5'd16;
   localparam logic [4:0]  MODE_ELASTIC_IN = 5'd22;
   localparam logic [4:0]  MODE_BACK_IN = 5'd25;
   localparam logic [4:0]  MODE_BOUNCE_INOUT = 5'd30;
   localparam logic [16:0] T_ONE       = 17'd65536;
   localparam logic [16:0] T_MAX       = 17'h1ffff;
   localparam longint      Q1          = 64'sd1 << 28;

   typedef struct {
      bit          is_write;
      logic [2:0]  addr;
      logic [31:0] data;
      logic [16:0] tval;
      bit          known;
      int          value;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [16:0] req_time_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [18:0] rsp_eased_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [18:0] eased_expect_q[$];
   logic [4:0]  mode_shadow = MODE_LINEAR;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          failures = 0;
   int          beats_sent = 0;
   int          beats_checked = 0;
   longint      cycles = 0;

   easing_curve_evaluator_top uut (
      .clock, .reset, .req_valid, .req_ready, .req_time_value, .rsp_valid, .rsp_ready,
      .rsp_eased_value, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #CLK_HALF clock = ~clock;

   // ---- curve model in Q28 ----
   function automatic longint q_mul(input longint a, input longint b);
      return (a * b + (64'sd1 << 27)) >>> 28;
   endfunction

   function automatic longint q_sin(input longint p);
      longint dens[5] = '{110, 72, 42, 20, 6};
      logic [63:0] up;
      logic [1:0]  quad;
      longint      f, z, z2, acc;
      up   = p;
      quad = up[29:28];
      f    = longint'(up & 64'(Q1 - 1));
      acc  = Q1;
      if (quad[0]) f = Q1 - f;
      z  = q_mul(f, HALF_PI_Q);
      z2 = q_mul(z, z);
      for (int i = 0; i < 5; i++) acc = Q1 - q_mul(z2, acc) / dens[i];
      acc = q_mul(z, acc);
      return quad[1] ? -acc : acc;
   endfunction

   function automatic longint q_pow2(input longint y);
      longint n, f, x, e, k;
      e = Q1;
      if (y > 0) y = 0;
      n = y >>> 28;
      f = y - n * Q1;
      x = q_mul(f, LN2_Q);
      for (int i = 10; i >= 1; i--) e = Q1 + q_mul(x, e) / i;
      k = -n;
      if (k >= 63) return 0;
      return e >>> k;
   endfunction

   function automatic longint q_sqrt(input longint x);
      longint unsigned v, res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      if (x < 0) x = 0;
      if (x > Q1) x = Q1;
      v = longint'(x) << 28;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint q_bounce_out(input longint w);
      longint u, d, c;
      u = 11 * w;
      if (u < 4 * Q1) begin
         d = u; c = 0;
      end else if (u < 8 * Q1) begin
         d = u - 6 * Q1; c = Q1 / 4 * 3;
      end else if (u < 10 * Q1) begin
         d = u - 9 * Q1; c = Q1 / 16 * 15;
      end else begin
         d = u - Q1 / 2 * 21; c = Q1 / 64 * 63;
      end
      return (q_mul(d, d) >>> 4) + c;
   endfunction

   // Family numbering follows the mode code: 1 quad through 10 bounce.
   function automatic longint ease_in_curve(input int fam, input longint v, input longint s);
      longint p;
      case (fam)
         1, 2, 3, 4: begin
            p = v;
            for (int i = 0; i < fam; i++) p = q_mul(p, v);
            return p;
         end
         5: return Q1 - q_sin(v + Q1);
         6: return (v == 0) ? 0 : q_pow2(10 * (v - Q1));
         7: return Q1 - q_sqrt(Q1 - q_mul(v, v));
         8: begin
            if (v == 0) return 0;
            if (v == Q1) return Q1;
            return -q_mul(q_pow2(10 * (v - Q1)), q_sin(10 * v - 11 * Q1));
         end
         9: return q_mul(q_mul(v, v), q_mul(s + Q1, v) - s);
         default: return Q1 - q_bounce_out(Q1 - v);
      endcase
   endfunction

   function automatic logic [18:0] eased_predict(input logic [4:0] mode, input logic [16:0] tin);
      longint t, r, s, sat;
      int     fam, kind;
      sat = 64'sd1 << 17;
      if (tin > T_ONE) tin = T_ONE;
      t = longint'(tin) << 12;
      if (mode == MODE_LINEAR) begin
         r = t;
      end else begin
         fam  = (mode - 1) / 3 + 1;
         kind = (mode - 1) % 3;
         s    = (kind == 2) ? BACK_S2_Q : BACK_S_Q;
         if (kind == 0) r = ease_in_curve(fam, t, s);
         else if (kind == 1) r = Q1 - ease_in_curve(fam, Q1 - t, s);
         else if (t < Q1 / 2) r = q_mul(ease_in_curve(fam, 2 * t, s), Q1 / 2);
         else r = Q1 - q_mul(ease_in_curve(fam, 2 * Q1 - 2 * t, s), Q1 / 2);
      end
      r = (r + (64'sd1 << 11)) >>> 12;
      if (r > sat) r = sat;
      if (r < -sat) r = -sat;
      return r[18:0];
   endfunction

   // ---- driving ----
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_MODE && data[4:0] != MODE_UNUSED) mode_shadow = data[4:0];
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (eased_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Entered at a rising edge; the beat stays offered until the edge that accepts it.
   task automatic send_sample(input logic [16:0] tval, input bit known, input int value);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_time_value <= tval;
      do @(posedge clock); while (!req_ready);
      eased_expect_q.push_back(known ? 19'(value) : eased_predict(mode_shadow, tval));
      beats_sent++;
   endtask

   function automatic logic [16:0] random_time();
      case ($urandom_range(9))
         0:       return 17'(T_ONE + $urandom_range(65535));
         1:       return ($urandom_range(1)) ? T_ONE : 17'd0;
         2:       return 17'($urandom_range(15));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   // ---- checking ----
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (eased_expect_q.size() == 0) begin
            $error("eased_value: unexpected beat %0d", rsp_eased_value);
            failures++;
         end else begin
            if (rsp_eased_value !== eased_expect_q[0]) begin
               $error("eased_value: expected %0d, got %0d",
                      $signed(eased_expect_q[0]), rsp_eased_value);
               failures++;
            end
            void'(eased_expect_q.pop_front());
            beats_checked++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out with %0d results outstanding", eased_expect_q.size());
         $display("easing_curve_evaluator_top regression: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      int           idle_send[3];
      int           idle_recv[3];
      logic [4:0]   seg_mode;
      idle_send = '{35, 82, 0};
      idle_recv = '{82, 35, 0};
      rows = '{
         '{0, 0, 0, 17'd0, 1, 0},
         '{0, 0, 0, T_ONE, 1, 65536},
         '{0, 0, 0, T_MAX, 1, 65536},
         '{0, 0, 0, 17'd32768, 1, 32768},
         '{0, 0, 0, 17'd1, 1, 1},
         '{1, ADDR_MODE, 32'(MODE_QUAD_IN), 0, 0, 0},
         '{0, 0, 0, T_ONE, 1, 65536},
         '{0, 0, 0, 17'd32768, 1, 16384},
         '{1, ADDR_MODE, 32'(MODE_EXPO_IN), 0, 0, 0},
         '{0, 0, 0, 17'd0, 1, 0},
         '{0, 0, 0, 17'd1, 0, 0},
         '{1, ADDR_MODE, 32'(MODE_ELASTIC_IN), 0, 0, 0},
         '{0, 0, 0, 17'd0, 1, 0},
         '{0, 0, 0, T_ONE, 1, 65536},
         '{0, 0, 0, T_MAX, 1, 65536},
         '{0, 0, 0, 17'd40000, 0, 0},
         // An unused mode code leaves elastic selected, as does a write to a spare address.
         '{1, ADDR_MODE, 32'(MODE_UNUSED), 0, 0, 0},
         '{0, 0, 0, 17'd0, 1, 0},
         '{1, ADDR_SPARE, 32'(MODE_LINEAR), 0, 0, 0},
         '{0, 0, 0, 17'd50000, 0, 0},
         '{1, ADDR_MODE, 32'(MODE_BACK_IN), 0, 0, 0},
         '{0, 0, 0, 17'd0, 1, 0},
         '{0, 0, 0, 17'd20000, 0, 0},
         '{1, ADDR_MODE, 32'(MODE_BOUNCE_INOUT), 0, 0, 0},
         '{0, 0, 0, 17'd30000, 0, 0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_write) begin
            drain_results();
            csr_write(rows[i].addr, rows[i].data);
         end else begin
            send_sample(rows[i].tval, rows[i].known, rows[i].value);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = idle_send[ph];
         recv_idle = idle_recv[ph];
         for (int seg = 0; seg < 11; seg++) begin
            // The mode change also serves as the sender's pause until all results are in.
            drain_results();
            seg_mode = 5'((ph * 11 + seg) % 31);
            csr_write(ADDR_MODE, {27'($urandom_range(32'h7ffffff)), seg_mode});
            if ($urandom_range(3) == 0) csr_write(ADDR_MODE, 32'(MODE_UNUSED));
            if ($urandom_range(3) == 0) csr_write(ADDR_SPARE, $urandom);
            for (int k = 0; k < SEG_ITEMS; k++) send_sample(random_time(), 0, 0);
         end
      end

      drain_results();
      $display("Covered all 31 curves, saturated time inputs and ignored register writes.");
      $display("Sent %0d samples and checked %0d results in %0d cycles.",
               beats_sent, beats_checked, cycles);
      if (failures == 0 && eased_expect_q.size() == 0) begin
         $display("easing_curve_evaluator_top regression: pass");
      end else begin
         $display("easing_curve_evaluator_top regression: fail");
      end
      $finish;
   end

endmodule
